// ===== hdl/oqcr_pkg.sv =====
// oqcr_pkg: shared types and codes for the ordered queue with conditional release
// no dependencies
`default_nettype none

package oqcr_pkg;

   localparam logic [1:0] CMD_APPEND  = 2'd0;
   localparam logic [1:0] CMD_POP     = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   localparam logic [2:0] KIND_APPENDED = 3'd0;
   localparam logic [2:0] KIND_DROPPED  = 3'd1;
   localparam logic [2:0] KIND_POPPED   = 3'd2;
   localparam logic [2:0] KIND_RELEASED = 3'd3;
   localparam logic [2:0] KIND_NONE     = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] now_time;
      logic [15:0] proc_id;
      logic [15:0] arrival_at;
      logic [15:0] cpu_need;
      logic [15:0] io_period;
      logic [15:0] io_wait;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] out_proc_id;
      logic [15:0] out_arrival_at;
      logic [15:0] out_cpu_need;
      logic [15:0] out_io_period;
      logic [15:0] out_io_wait;
      logic [15:0] out_stamp;
      logic        last;
      logic [4:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [15:0] proc_id;
      logic [15:0] arrival_at;
      logic [15:0] cpu_need;
      logic [15:0] io_period;
      logic [15:0] io_wait;
      logic [15:0] stamp;
   } rec_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } slot_type;

endpackage

`default_nettype wire

// ===== hdl/oqcr_ram.sv =====
// oqcr_ram: generic simple dual-port ram with registered read
// no dependencies
`default_nettype none

module oqcr_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                     wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/oqcr_front.sv =====
// oqcr_front: command intake, two-entry command queue ahead of the engine
// depends on oqcr_pkg
`default_nettype none

module oqcr_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire oqcr_pkg::req_type req_data,
   output oqcr_pkg::slot_type     head,
   input  wire logic              take
);

   oqcr_pkg::req_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;
   assign pop  = take && (cnt_ff != 2'd0);

   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/oqcr_back.sv =====
// oqcr_back: command engine over a ring of records held in ram
// depends on oqcr_pkg and oqcr_ram
`default_nettype none

module oqcr_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              release_mode,
   input  wire oqcr_pkg::slot_type head,
   output logic                   take,
   output logic                   rsp_strobe,
   output oqcr_pkg::rsp_type      rsp_data
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int RW = $bits(oqcr_pkg::rec_type);
   localparam logic [CW:0] DEPTH_W = (CW + 1)'(QUEUE_DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_POPRD = 3'd2;
   localparam logic [2:0] S_CNT   = 3'd3;
   localparam logic [2:0] S_REL   = 3'd4;

   logic [2:0]        state_ff, state_in;
   oqcr_pkg::req_type cur_ff, cur_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic [CW-1:0]     rel_ff, rel_in;
   logic [CW-1:0]     kept_ff, kept_in;
   logic [CW-1:0]     emitted_ff, emitted_in;
   logic              strobe_ff, strobe_in;
   oqcr_pkg::rsp_type rsp_ff, rsp_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   oqcr_pkg::rec_type ram_wdata, ram_rdata;
   logic [RW-1:0]     ram_rbits;
   logic              hit;
   logic [15:0]       elapsed;

   function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW + 1)'(base) + (CW + 1)'(off);
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return AW'(sum);
   endfunction

   oqcr_ram #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rbits)
   );

   assign ram_rdata = ram_rbits;
   assign elapsed   = cur_ff.now_time - ram_rdata.stamp;
   assign hit       = release_mode ? (elapsed >= ram_rdata.io_wait)
                                   : (cur_ff.now_time == ram_rdata.arrival_at);
   assign take      = (state_ff == S_IDLE) && head.valid;

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      rel_in     = rel_ff;
      kept_in    = kept_ff;
      emitted_in = emitted_ff;
      strobe_in  = 1'b0;
      rsp_in     = '0;
      rsp_in.kind      = oqcr_pkg::KIND_NONE;
      rsp_in.last      = 1'b1;
      rsp_in.occupancy = 5'(count_ff);
      ram_we    = 1'b0;
      ram_waddr = wrap(head_ff, count_ff);
      ram_wdata = '0;
      ram_raddr = wrap(head_ff, scan_ff);

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               cur_in   = head.item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (cur_ff.cmd)
               oqcr_pkg::CMD_APPEND: begin
                  rsp_in.out_proc_id    = cur_ff.proc_id;
                  rsp_in.out_arrival_at = cur_ff.arrival_at;
                  rsp_in.out_cpu_need   = cur_ff.cpu_need;
                  rsp_in.out_io_period  = cur_ff.io_period;
                  rsp_in.out_io_wait    = cur_ff.io_wait;
                  rsp_in.out_stamp      = cur_ff.now_time;
                  strobe_in             = 1'b1;
                  if ((CW + 1)'(count_ff) < DEPTH_W) begin
                     ram_we              = 1'b1;
                     ram_wdata.proc_id    = cur_ff.proc_id;
                     ram_wdata.arrival_at = cur_ff.arrival_at;
                     ram_wdata.cpu_need   = cur_ff.cpu_need;
                     ram_wdata.io_period  = cur_ff.io_period;
                     ram_wdata.io_wait    = cur_ff.io_wait;
                     ram_wdata.stamp      = cur_ff.now_time;
                     count_in             = count_ff + 1'b1;
                     rsp_in.kind          = oqcr_pkg::KIND_APPENDED;
                     rsp_in.occupancy     = 5'(count_in);
                  end else begin
                     rsp_in.kind = oqcr_pkg::KIND_DROPPED;
                  end
               end
               oqcr_pkg::CMD_POP: begin
                  ram_raddr = head_ff;
                  if (count_ff != '0) begin
                     state_in = S_POPRD;
                  end else begin
                     strobe_in = 1'b1;
                  end
               end
               oqcr_pkg::CMD_RELEASE: begin
                  if (count_ff != '0) begin
                     scan_in  = '0;
                     rel_in   = '0;
                     state_in = S_CNT;
                  end else begin
                     strobe_in = 1'b1;
                  end
               end
               default: begin
                  strobe_in = 1'b1;
               end
            endcase
         end
         S_POPRD: begin
            rsp_in.kind           = oqcr_pkg::KIND_POPPED;
            rsp_in.out_proc_id    = ram_rdata.proc_id;
            rsp_in.out_arrival_at = ram_rdata.arrival_at;
            rsp_in.out_cpu_need   = ram_rdata.cpu_need;
            rsp_in.out_io_period  = ram_rdata.io_period;
            rsp_in.out_io_wait    = ram_rdata.io_wait;
            rsp_in.out_stamp      = ram_rdata.stamp;
            count_in              = count_ff - 1'b1;
            rsp_in.occupancy      = 5'(count_in);
            head_in               = wrap(head_ff, CW'(1));
            strobe_in             = 1'b1;
            state_in              = S_IDLE;
         end
         S_CNT: begin
            if (scan_ff != '0 && hit) begin
               rel_in = rel_ff + 1'b1;
            end
            if (scan_ff == count_ff) begin
               if (rel_in == '0) begin
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  scan_in    = '0;
                  kept_in    = '0;
                  emitted_in = '0;
                  state_in   = S_REL;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_REL: begin
            ram_waddr = wrap(head_ff, kept_ff);
            ram_wdata = ram_rdata;
            if (scan_ff != '0) begin
               if (hit) begin
                  rsp_in.kind           = oqcr_pkg::KIND_RELEASED;
                  rsp_in.out_proc_id    = ram_rdata.proc_id;
                  rsp_in.out_arrival_at = ram_rdata.arrival_at;
                  rsp_in.out_cpu_need   = ram_rdata.cpu_need;
                  rsp_in.out_io_period  = ram_rdata.io_period;
                  rsp_in.out_io_wait    = ram_rdata.io_wait;
                  rsp_in.out_stamp      = cur_ff.now_time;
                  rsp_in.occupancy      = 5'(count_ff - rel_ff);
                  rsp_in.last           = (CW'(emitted_ff + 1'b1) == rel_ff);
                  emitted_in            = emitted_ff + 1'b1;
                  strobe_in             = 1'b1;
               end else begin
                  ram_we  = 1'b1;
                  kept_in = kept_ff + 1'b1;
               end
            end
            if (scan_ff == count_ff) begin
               count_in = count_ff - rel_ff;
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      scan_ff    <= scan_in;
      rel_ff     <= rel_in;
      kept_ff    <= kept_in;
      emitted_ff <= emitted_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (CW + 1)'(count_ff) <= DEPTH_W)
      else $error("record count above depth");
   a_multi_only_release: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && !rsp_ff.last |-> rsp_ff.kind == oqcr_pkg::KIND_RELEASED)
      else $error("non-final result outside a release");
   a_rel_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REL |-> rel_ff != '0)
      else $error("release pass with nothing to release");
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REL |-> emitted_ff <= rel_ff)
      else $error("more releases than counted");
   a_busy_engine: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |=> !take || $past(state_in) == S_IDLE)
      else $error("command taken while engine busy");

endmodule

`default_nettype wire

// ===== hdl/ordered_queue_conditional_release_top.sv =====
// ordered_queue_conditional_release_top: ordered record queue with conditional release
// depends on oqcr_pkg, oqcr_front, oqcr_back, oqcr_ram
`default_nettype none

// Commands enter through a two-entry command queue; busy rises only when it is full.
// The engine runs one command at a time; a release that finds any match walks the
// held records twice through the one ram read port (a counting pass, then an emit
// and compact pass), and one that finds none stops after the counting pass. Results
// come out on rsp_strobe and cannot be held off; a release with several matches
// streams them with last on the final one. The release_mode register is written
// through the csr channel, which is always ready.
module ordered_queue_conditional_release_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire oqcr_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output oqcr_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_data
);

   oqcr_pkg::slot_type head;
   logic               take;
   logic               mode_ff, mode_in;

   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   oqcr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .head     (head),
      .take     (take)
   );

   oqcr_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock        (clock),
      .reset        (reset),
      .release_mode (mode_ff),
      .head         (head),
      .take         (take),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

// ===== test/oqcr_checker.sv =====
// oqcr_checker: watches the command, result and csr channels of the record queue,
// predicts every result from its own copy of the queue and compares them in order
// depends on oqcr_pkg
`default_nettype none

module oqcr_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire oqcr_pkg::req_type req_data,
   input  wire logic              rsp_strobe,
   input  wire oqcr_pkg::rsp_type rsp_data,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic              csr_data,
   output int                     fail_count,
   output int                     pending
);

   localparam int DEPTH = 16;

   oqcr_pkg::rec_type held_q[$];
   oqcr_pkg::rsp_type expected_rsp_q[$];
   logic              wait_mode;

   function automatic oqcr_pkg::rsp_type make_rsp(logic [2:0] kind,
                                                  oqcr_pkg::rec_type rec);
      oqcr_pkg::rsp_type r;
      r.kind           = kind;
      r.out_proc_id    = rec.proc_id;
      r.out_arrival_at = rec.arrival_at;
      r.out_cpu_need   = rec.cpu_need;
      r.out_io_period  = rec.io_period;
      r.out_io_wait    = rec.io_wait;
      r.out_stamp      = rec.stamp;
      r.last           = 1'b0;
      r.occupancy      = '0;
      return r;
   endfunction

   function automatic logic is_releasable(oqcr_pkg::rec_type rec, logic [15:0] now);
      logic [15:0] elapsed;
      elapsed = now - rec.stamp;
      if (wait_mode) return elapsed >= rec.io_wait;
      return now == rec.arrival_at;
   endfunction

   // works out the results of one command and updates the held records
   function automatic void predict_command(oqcr_pkg::req_type req);
      oqcr_pkg::rsp_type results[$];
      oqcr_pkg::rec_type kept_q[$];
      oqcr_pkg::rec_type rec;
      rec.proc_id    = req.proc_id;
      rec.arrival_at = req.arrival_at;
      rec.cpu_need   = req.cpu_need;
      rec.io_period  = req.io_period;
      rec.io_wait    = req.io_wait;
      rec.stamp      = req.now_time;
      case (req.cmd)
         oqcr_pkg::CMD_APPEND: begin
            if (held_q.size() < DEPTH) begin
               held_q.push_back(rec);
               results.push_back(make_rsp(oqcr_pkg::KIND_APPENDED, rec));
            end else begin
               results.push_back(make_rsp(oqcr_pkg::KIND_DROPPED, rec));
            end
         end
         oqcr_pkg::CMD_POP: begin
            if (held_q.size() > 0)
               results.push_back(make_rsp(oqcr_pkg::KIND_POPPED, held_q.pop_front()));
            else results.push_back(make_rsp(oqcr_pkg::KIND_NONE, '0));
         end
         oqcr_pkg::CMD_RELEASE: begin
            foreach (held_q[i]) begin
               if (is_releasable(held_q[i], req.now_time)) begin
                  rec = held_q[i];
                  rec.stamp = req.now_time;
                  results.push_back(make_rsp(oqcr_pkg::KIND_RELEASED, rec));
               end else begin
                  kept_q.push_back(held_q[i]);
               end
            end
            held_q = kept_q;
            if (results.size() == 0) results.push_back(make_rsp(oqcr_pkg::KIND_NONE, '0));
         end
         default: results.push_back(make_rsp(oqcr_pkg::KIND_NONE, '0));
      endcase
      foreach (results[i]) begin
         results[i].occupancy = 5'(held_q.size());
         results[i].last      = (i == results.size() - 1);
         expected_rsp_q.push_back(results[i]);
      end
   endfunction

   always @(posedge clock) begin
      oqcr_pkg::rsp_type exp_rsp;
      if (reset) begin
         held_q.delete();
         expected_rsp_q.delete();
         wait_mode  = 1'b0;
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               $display("%0t: result with nothing expected, got %h", $time, rsp_data);
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_data.kind !== exp_rsp.kind ||
                   rsp_data.out_proc_id !== exp_rsp.out_proc_id ||
                   rsp_data.out_arrival_at !== exp_rsp.out_arrival_at ||
                   rsp_data.out_cpu_need !== exp_rsp.out_cpu_need ||
                   rsp_data.out_io_period !== exp_rsp.out_io_period ||
                   rsp_data.out_io_wait !== exp_rsp.out_io_wait ||
                   rsp_data.out_stamp !== exp_rsp.out_stamp ||
                   rsp_data.last !== exp_rsp.last ||
                   rsp_data.occupancy !== exp_rsp.occupancy) begin
                  fail_count++;
                  $display("%0t: result mismatch, expected %p, got %p", $time, exp_rsp,
                           rsp_data);
               end
            end
         end
         if (start && !busy) predict_command(req_data);
         if (csr_valid && csr_ready) wait_mode = csr_data;
      end
      pending = expected_rsp_q.size();
   end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench: drives directed and random commands and release_mode writes into the
// record queue and reports the verdict from the checker's failure count
// depends on oqcr_pkg, oqcr_checker, ordered_queue_conditional_release_top
`default_nettype none

module testbench;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 109;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   oqcr_pkg::req_type req_data;
   logic              rsp_strobe;
   oqcr_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_data;
   int                fail_count;
   int                pending;
   int                quiet_cycles;
   logic [15:0]       sim_now;

   ordered_queue_conditional_release_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   oqcr_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data), .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_command(oqcr_pkg::req_type req);
      start    = 1'b1;
      req_data = req;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic idle_gap(int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // the engine may still be compacting after the last result of a release
   task automatic write_mode(logic mode);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = mode;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic oqcr_pkg::req_type make_req(logic [1:0] cmd, logic [15:0] now,
                                                  logic [15:0] id, logic [15:0] arr,
                                                  logic [15:0] cpu, logic [15:0] per,
                                                  logic [15:0] wt);
      oqcr_pkg::req_type r;
      r.cmd = cmd; r.now_time = now; r.proc_id = id; r.arrival_at = arr;
      r.cpu_need = cpu; r.io_period = per; r.io_wait = wt;
      return r;
   endfunction

   function automatic oqcr_pkg::req_type random_command();
      oqcr_pkg::req_type r;
      int                pick;
      logic [127:0]      raw;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         raw = {$urandom, $urandom, $urandom, $urandom};
         r   = raw[$bits(oqcr_pkg::req_type)-1:0];
         return r;
      end
      r.now_time   = sim_now;
      r.proc_id    = 16'($urandom);
      r.cpu_need   = 16'($urandom);
      r.io_period  = 16'($urandom);
      r.arrival_at = sim_now + 16'($urandom_range(0, 12));
      r.io_wait    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
      pick = $urandom_range(0, 99);
      if (pick < 50) r.cmd = oqcr_pkg::CMD_APPEND;
      else if (pick < 64) r.cmd = oqcr_pkg::CMD_POP;
      else if (pick < 97) r.cmd = oqcr_pkg::CMD_RELEASE;
      else r.cmd = oqcr_pkg::CMD_UNUSED;
      return r;
   endfunction

   initial begin
      oqcr_pkg::req_type req;
      int                burst;
      int                sent;
      logic              phase_mode;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = 1'b0;
      sim_now      = 16'd0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed: empty cases, fill past full, arrival releases
      write_mode(1'b0);
      send_command(make_req(oqcr_pkg::CMD_POP, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_command(make_req(oqcr_pkg::CMD_RELEASE, 16'd7, 16'd0, 16'd0, 16'd0, 16'd0,
                            16'd0));
      send_command(make_req(oqcr_pkg::CMD_UNUSED, '1, '1, '1, '1, '1, '1));
      for (int i = 0; i < 16; i++) begin
         if (i == 0)
            req = make_req(oqcr_pkg::CMD_APPEND, 16'd0, 16'd0, 16'd100, 16'd0, 16'd0,
                           16'd0);
         else if (i == 15)
            req = make_req(oqcr_pkg::CMD_APPEND, 16'd50, '1, '1, '1, '1, '1);
         else
            req = make_req(oqcr_pkg::CMD_APPEND, 16'd50, 16'(i),
                           (i % 3 == 0) ? 16'd100 : 16'd200, 16'(i), 16'(i), 16'(i));
         send_command(req);
      end
      send_command(make_req(oqcr_pkg::CMD_APPEND, '1, '1, '1, '1, '1, '1));
      send_command(make_req(oqcr_pkg::CMD_RELEASE, 16'd100, 16'd0, 16'd0, 16'd0, 16'd0,
                            16'd0));
      send_command(make_req(oqcr_pkg::CMD_POP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_command(make_req(oqcr_pkg::CMD_RELEASE, 16'd200, 16'd0, 16'd0, 16'd0, 16'd0,
                            16'd0));
      send_command(make_req(oqcr_pkg::CMD_RELEASE, '1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));

      // random phases, alternating modes
      for (int phase = 0; phase < 4; phase++) begin
         phase_mode = (phase % 2 == 0);
         write_mode(phase_mode);
         sim_now = (phase == 2) ? 16'hFFE0 : 16'($urandom);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
               send_command(random_command());
               sim_now = sim_now + 16'($urandom_range(0, 3));
               sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 15));
         end
      end

      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
